@@ design/pp2w_pkg.sv @@
// shared types, codes and helpers for the point-to-window projector
package pp2w_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_VP_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VP_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VP_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VP_HEIGHT = 2'd3;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_RD       = 10'b0000000010,
    S_MUL      = 10'b0000000100,
    S_ACC      = 10'b0000001000,
    S_CHK      = 10'b0000010000,
    S_DIV_GO   = 10'b0000100000,
    S_DIV_WAIT = 10'b0001000000,
    S_WIN_MUL  = 10'b0010000000,
    S_WIN_ADD  = 10'b0100000000,
    S_OUT      = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic       coef_wr;
    logic       pos_cap;
    logic [4:0] mac_idx;
    logic       mul;
    logic       acc;
    logic       div_start;
    logic       axis;
    logic       win_mul;
    logic       win_add;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic w_zero;
    logic div_done;
    logic out_free;
  } status_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -64'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ design/project_point_to_window.sv @@
// top level of the point-to-window projector
//
//   channel  direction  handshake            payload
//   in       in         in_valid / in_stall  op, coef_index, coef_value, pos_x/y/z
//   out      out        out_valid/out_stall  win_x, win_y, ok
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a load transfer writes one coefficient; a project item's time is set by
// the one shared multiply-accumulate (read, multiply and accumulate steps per
// term, 32 terms) and the one-bit-per-cycle divider run twice; a zero clip w
// skips the divisions
// reset restores the viewport defaults; coefficients are undefined until loaded
// a stalled result holds in the output register while the next item is taken
module project_point_to_window import pp2w_pkg::*; #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic [4:0]           coef_index,
  input  logic signed [31:0]   coef_value,
  input  logic signed [31:0]   pos_x,
  input  logic signed [31:0]   pos_y,
  input  logic signed [31:0]   pos_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   win_x,
  output logic signed [31:0]   win_y,
  output logic                 ok,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [13:0]          cfg_data
);

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  pp2w_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (op),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  pp2w_dp #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .win_x      (win_x),
    .win_y      (win_y),
    .ok         (ok)
  );

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> win_x == 32'sd0 && win_y == 32'sd0)
    else $error("failed projection carries non-zero window coordinates");

  a_project_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == OP_PROJECT |=> in_stall)
    else $error("project transfer did not start the sequence");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == OP_LOAD && !out_valid |=> !out_valid)
    else $error("coefficient load produced a result");

endmodule

@@ design/pp2w_ram.sv @@
// generic single write port ram with registered read
module pp2w_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ design/pp2w_ctrl.sv @@
// sequencing state machine for the projector
module pp2w_ctrl import pp2w_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_op,
  output logic    in_stall,
  output cmd_t    cmd,
  input  status_t sts
);

  state_t     state, state_next;
  logic [4:0] idx, idx_next;
  logic       axis, axis_next;
  logic       accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    axis_next  = axis;
    cmd        = '0;
    cmd.mac_idx = idx;
    cmd.axis    = axis;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_PROJECT) begin
            cmd.pos_cap = 1'b1;
            idx_next    = '0;
            axis_next   = 1'b0;
            state_next  = S_RD;
          end else begin
            cmd.coef_wr = 1'b1;
          end
        end
      end
      S_RD:  state_next = S_MUL;
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc  = 1'b1;
        idx_next = idx + 5'd1;
        state_next = (idx == 5'd31) ? S_CHK : S_RD;
      end
      S_CHK: state_next = sts.w_zero ? S_OUT : S_DIV_GO;
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: if (sts.div_done) state_next = S_WIN_MUL;
      S_WIN_MUL: begin
        cmd.win_mul = 1'b1;
        state_next  = S_WIN_ADD;
      end
      S_WIN_ADD: begin
        cmd.win_add = 1'b1;
        axis_next   = 1'b1;
        state_next  = axis ? S_OUT : S_DIV_GO;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      axis  <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      axis  <= axis_next;
    end
  end

endmodule

@@ design/pp2w_dp.sv @@
// datapath: coefficient store, shared mac, divider and viewport mapping
module pp2w_dp import pp2w_pkg::*; #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              sts,
  input  logic [4:0]           coef_index,
  input  logic signed [31:0]   coef_value,
  input  logic signed [31:0]   pos_x,
  input  logic signed [31:0]   pos_y,
  input  logic signed [31:0]   pos_z,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [13:0]          cfg_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic signed [31:0]   win_x,
  output logic signed [31:0]   win_y,
  output logic                 ok
);

  localparam int NW    = 32 + COEF_FRAC_BITS;
  localparam int CNT_W = $clog2(NW + 1);
  localparam int CW    = (NW > 47) ? NW : 47;

  // viewport registers
  logic [13:0] vp_x, vp_y, vp_w, vp_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp_x <= 14'd0;
      vp_y <= 14'd0;
      vp_w <= 14'd640;
      vp_h <= 14'd480;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VP_X:      vp_x <= cfg_data;
        CFG_VP_Y:      vp_y <= cfg_data;
        CFG_VP_WIDTH:  vp_w <= cfg_data;
        CFG_VP_HEIGHT: vp_h <= cfg_data;
        default:       ;
      endcase
    end
  end

  // coefficient store, slot c*4+r of each matrix
  logic [31:0] rdata;
  logic [1:0]  mc, mr;
  assign mc = cmd.mac_idx[1:0];
  assign mr = cmd.mac_idx[3:2];

  pp2w_ram #(.WIDTH(32), .DEPTH(32)) u_coef (
    .clk   (clk),
    .we    (cmd.coef_wr),
    .waddr (coef_index),
    .wdata (coef_value),
    .raddr ({cmd.mac_idx[4], mc, mr}),
    .rdata (rdata)
  );

  logic signed [31:0] px, py, pz;
  logic signed [31:0] eye  [4];
  logic signed [31:0] clip [4];
  logic signed [31:0] src;
  logic signed [63:0] prod, acc, sum;

  always_comb begin
    if (cmd.mac_idx[4]) begin
      src = eye[mc];
    end else begin
      case (mc)
        2'd0:    src = px;
        2'd1:    src = py;
        2'd2:    src = pz;
        default: src = 32'sd1 <<< COEF_FRAC_BITS;
      endcase
    end
  end

  // floor shift of the exact product
  assign sum = acc + (prod >>> COEF_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (cmd.pos_cap) begin
      px  <= pos_x;
      py  <= pos_y;
      pz  <= pos_z;
      acc <= '0;
    end
    if (cmd.mul) prod <= $signed(rdata) * src;
    if (cmd.acc) begin
      if (mc == 2'd3) begin
        acc <= '0;
        if (cmd.mac_idx[4]) clip[mr] <= sat32(sum);
        else eye[mr] <= sat32(sum);
      end else begin
        acc <= sum;
      end
    end
  end

  // restoring divider on magnitudes, one quotient bit per cycle
  logic signed [31:0] num;
  logic [31:0]        nmag, dmag;
  logic [NW-1:0]      dvd;
  logic [31:0]        rem;
  logic [32:0]        rem_sh;
  logic [CNT_W-1:0]   dcnt;
  logic               busy, qneg;

  assign num    = cmd.axis ? clip[1] : clip[0];
  assign nmag   = num[31] ? 32'(-num) : 32'(num);
  assign rem_sh = {rem, dvd[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.div_start) begin
      busy <= 1'b1;
    end else if (busy && dcnt == CNT_W'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd  <= {nmag, {COEF_FRAC_BITS{1'b0}}};
      rem  <= '0;
      dmag <= clip[3][31] ? 32'(-clip[3]) : 32'(clip[3]);
      qneg <= num[31] ^ clip[3][31];
      dcnt <= CNT_W'(NW);
    end else if (busy) begin
      dcnt <= dcnt - CNT_W'(1);
      if (rem_sh >= {1'b0, dmag}) begin
        rem <= 32'(rem_sh - {1'b0, dmag});
        dvd <= {dvd[NW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        dvd <= {dvd[NW-2:0], 1'b0};
      end
    end
  end

  // clamp the quotient magnitude to 2**46, restore sign, map through the viewport
  logic [CW-1:0]      qext, qlim;
  logic [46:0]        qclamp;
  logic signed [47:0] q;
  logic signed [48:0] half, one49;
  logic signed [14:0] size;
  logic signed [63:0] prod_w, org, wsum;
  logic [31:0]        res_x, res_y;

  assign qext   = CW'(dvd);
  assign qlim   = CW'(1) << 46;
  assign qclamp = (qext > qlim) ? qlim[46:0] : qext[46:0];
  assign q      = qneg ? -$signed({1'b0, qclamp}) : $signed({1'b0, qclamp});
  assign one49  = 49'sd1 <<< COEF_FRAC_BITS;
  assign half   = cmd.axis ? (one49 - 49'(q)) : (one49 + 49'(q));
  assign size   = $signed({1'b0, cmd.axis ? vp_h : vp_w});
  assign org    = $signed({50'd0, cmd.axis ? vp_y : vp_x}) <<< COEF_FRAC_BITS;
  assign wsum   = org + (prod_w >>> 1);

  always_ff @(posedge clk) begin
    if (cmd.win_mul) prod_w <= half * size;
    if (cmd.win_add) begin
      if (cmd.axis) res_y <= sat32(wsum);
      else res_x <= sat32(wsum);
    end
  end

  // output register
  assign sts.w_zero   = (clip[3] == 32'sd0);
  assign sts.div_done = !busy;
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ok    <= !sts.w_zero;
      win_x <= sts.w_zero ? 32'sd0 : $signed(res_x);
      win_y <= sts.w_zero ? 32'sd0 : $signed(res_y);
    end
  end

endmodule
